/* hdl/sts_pkg.sv */
`default_nettype none

package sts_pkg;

   // scan state, one-hot
   typedef enum logic [3:0] {
      SCAN_IDLE  = 4'b0001,
      SCAN_NUM   = 4'b0010,
      SCAN_SYM   = 4'b0100,
      SCAN_MINUS = 4'b1000
   } scan_state_type;

   localparam logic [3:0] KIND_OPEN  = 4'd0;
   localparam logic [3:0] KIND_CLOSE = 4'd1;
   localparam logic [3:0] KIND_OP    = 4'd2;
   localparam logic [3:0] KIND_NUM   = 4'd3;
   localparam logic [3:0] KIND_SYM   = 4'd4;
   localparam logic [3:0] KIND_DEFUN = 4'd5;
   localparam logic [3:0] KIND_IF    = 4'd6;
   localparam logic [3:0] KIND_SETQ  = 4'd7;
   localparam logic [3:0] KIND_END   = 4'd8;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic [11:0] LEN_LIMIT = 12'hFFF;
   localparam logic [11:0] POS_LIMIT = 12'hFFF;

   typedef struct packed {
      logic [3:0]  kind;
      logic [11:0] len;
      logic [7:0]  first;
      logic [11:0] start;
      logic        last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL};
   endfunction

   function automatic logic is_op(input logic [7:0] b);
      return b inside {8'h2F, 8'h2B, 8'h2A, 8'h3D, 8'h3C, 8'h3E};
   endfunction

   // keyword letter at position idx; a low in_range forces a miss
   function automatic logic kw_hit(input logic [1:0] k, input logic [2:0] idx,
                                   input logic in_range, input logic [7:0] b);
      logic [7:0] ch;
      logic       ok;
      ch = 8'h00;
      ok = 1'b0;
      case (k)
         2'd0: begin
            ok = in_range && (idx < 3'd5);
            case (idx)
               3'd0:    ch = 8'h64; // d
               3'd1:    ch = 8'h65; // e
               3'd2:    ch = 8'h66; // f
               3'd3:    ch = 8'h75; // u
               3'd4:    ch = 8'h6E; // n
               default: ch = 8'h00;
            endcase
         end
         2'd1: begin
            ok = in_range && (idx < 3'd2);
            case (idx)
               3'd0:    ch = 8'h69; // i
               3'd1:    ch = 8'h66; // f
               default: ch = 8'h00;
            endcase
         end
         2'd2: begin
            ok = in_range && (idx < 3'd4);
            case (idx)
               3'd0:    ch = 8'h73; // s
               3'd1:    ch = 8'h65; // e
               3'd2:    ch = 8'h74; // t
               3'd3:    ch = 8'h71; // q
               default: ch = 8'h00;
            endcase
         end
         default: ok = 1'b0;
      endcase
      return ok && (ch == b);
   endfunction

endpackage

`default_nettype wire

/* hdl/sexpr_token_scanner_core.sv */
// A token is written into the result queue at the clock edge that takes the byte that closes it.
// One byte per cycle while req_tready is high; a byte that closes two tokens at once needs
// two result beats, so the 4-entry result queue sets the rate then.
// req_tready is high while at most two queue entries are in use.
// Reset (synchronous, active high) empties the queue and returns the scanner
// to idle with line position zero; no clearing pass.
`default_nettype none

module sexpr_token_scanner_core
   import sts_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 4095
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [3:0] token_kind, [15:4] token_length,
                                         // [23:16] first_char, [35:24] start_pos
   output logic             rsp_tlast    // last
);

   localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
   localparam int EW = (LW > 12) ? LW : 12;

   scan_state_type   state_ff, state_in;
   logic [LW-1:0]    run_len_ff, run_len_in;
   logic [11:0]      run_start_ff, run_start_in;
   logic [11:0]      line_pos_ff, line_pos_in;
   logic [2:0]       alive_ff, alive_in;
   logic [7:0]       run_first_ff, run_first_in;

   token_type        queue_ff [4];
   logic [1:0]       wptr_ff, rptr_ff;
   logic [2:0]       count_ff;

   logic             accept, pop;
   logic [7:0]       b;
   logic [EW-1:0]    len_ext;
   logic [11:0]      rep_len;
   logic [LW-1:0]    len_inc;
   logic [3:0]       flush_kind;
   token_type        flush_tok;
   token_type        e0, e1, slot_a;
   logic             e0_v, e1_v, fresh;
   logic [2:0]       alive_cont, alive_new;
   logic [1:0]       n_push;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign b      = req_tdata;

   assign len_ext = EW'(run_len_ff);
   assign rep_len = (len_ext > EW'(LEN_LIMIT)) ? LEN_LIMIT : len_ext[11:0];
   assign len_inc = (run_len_ff >= LW'(MAX_TOKEN_LEN)) ? run_len_ff : run_len_ff + 1'b1;

   // keyword tracking: position is the current run length
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         alive_cont[k] = alive_ff[k] &&
                         kw_hit(2'(k), len_ext[2:0], len_ext < EW'(5), b);
         alive_new[k]  = kw_hit(2'(k), 3'd0, 1'b1, b);
      end
   end

   always_comb begin
      flush_kind = KIND_NUM;
      if (state_ff == SCAN_SYM) begin
         if (alive_ff[0] && len_ext == EW'(5))
            flush_kind = KIND_DEFUN;
         else if (alive_ff[1] && len_ext == EW'(2))
            flush_kind = KIND_IF;
         else if (alive_ff[2] && len_ext == EW'(4))
            flush_kind = KIND_SETQ;
         else
            flush_kind = KIND_SYM;
      end
      flush_tok = '{kind: flush_kind, len: rep_len, first: run_first_ff,
                    start: run_start_ff, last: 1'b0};
   end

   always_comb begin
      state_in     = state_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      line_pos_in  = line_pos_ff;
      alive_in     = alive_ff;
      run_first_in = run_first_ff;
      e0_v  = 1'b0;
      e1_v  = 1'b0;
      e0    = flush_tok;
      e1    = '{kind: KIND_END, len: 12'd0, first: 8'd0, start: line_pos_ff, last: 1'b0};
      fresh = 1'b1;
      if (req_tuser) begin
         e0_v         = (state_ff != SCAN_IDLE);
         e1_v         = 1'b1;
         state_in     = SCAN_IDLE;
         run_len_in   = '0;
         run_start_in = '0;
         line_pos_in  = '0;
         alive_in     = 3'b111;
         run_first_in = '0;
      end else begin
         case (state_ff)
            SCAN_MINUS: begin
               if (b == CH_SPACE) begin
                  e0_v     = 1'b1;
                  e0       = '{kind: KIND_OP, len: 12'd1, first: run_first_ff,
                               start: run_start_ff, last: 1'b0};
                  state_in = SCAN_IDLE;
                  fresh    = 1'b0;
               end else if (is_digit(b)) begin
                  state_in   = SCAN_NUM;
                  run_len_in = len_inc;
                  fresh      = 1'b0;
               end else begin
                  e0_v     = 1'b1;
                  state_in = SCAN_IDLE;
               end
            end
            SCAN_NUM: begin
               if (is_digit(b)) begin
                  run_len_in = len_inc;
                  fresh      = 1'b0;
               end else begin
                  e0_v     = 1'b1;
                  state_in = SCAN_IDLE;
               end
            end
            SCAN_SYM: begin
               if (!is_space(b) && b != CH_OPEN && b != CH_CLOSE) begin
                  alive_in   = alive_cont;
                  run_len_in = len_inc;
                  fresh      = 1'b0;
               end else begin
                  e0_v     = 1'b1;
                  state_in = SCAN_IDLE;
               end
            end
            default: ;
         endcase

         if (fresh && !is_space(b)) begin
            e1 = '{kind: KIND_OP, len: 12'd1, first: b, start: line_pos_ff, last: 1'b0};
            if (b == CH_OPEN) begin
               e1_v    = 1'b1;
               e1.kind = KIND_OPEN;
            end else if (b == CH_CLOSE) begin
               e1_v    = 1'b1;
               e1.kind = KIND_CLOSE;
            end else if (is_op(b)) begin
               e1_v = 1'b1;
            end else begin
               run_len_in   = LW'(1);
               run_start_in = line_pos_ff;
               run_first_in = b;
               alive_in     = 3'b111;
               if (b == CH_MINUS) begin
                  state_in = SCAN_MINUS;
               end else if (is_digit(b)) begin
                  state_in = SCAN_NUM;
               end else begin
                  state_in = SCAN_SYM;
                  alive_in = alive_new;
               end
            end
         end

         line_pos_in = (b == CH_LF) ? 12'd0 :
                       (line_pos_ff == POS_LIMIT) ? POS_LIMIT : line_pos_ff + 12'd1;
      end

      if (e1_v)
         e1.last = 1'b1;
      else
         e0.last = 1'b1;
   end

   assign slot_a = e0_v ? e0 : e1;
   assign n_push = accept ? (2'(e0_v) + 2'(e1_v)) : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_IDLE;
         run_len_ff   <= '0;
         run_start_ff <= '0;
         line_pos_ff  <= '0;
         alive_ff     <= 3'b111;
         run_first_ff <= '0;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            run_len_ff   <= run_len_in;
            run_start_ff <= run_start_in;
            line_pos_ff  <= line_pos_in;
            alive_ff     <= alive_in;
            run_first_ff <= run_first_in;
         end
         wptr_ff  <= wptr_ff + n_push;
         rptr_ff  <= rptr_ff + 2'(pop);
         count_ff <= count_ff + 3'(n_push) - 3'(pop);
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (n_push != 2'd0)
         queue_ff[wptr_ff] <= slot_a;
      if (n_push == 2'd2)
         queue_ff[wptr_ff + 2'd1] <= e1;
   end

   assign req_tready = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {4'b0000, queue_ff[rptr_ff].start, queue_ff[rptr_ff].first,
                        queue_ff[rptr_ff].len, queue_ff[rptr_ff].kind};
   assign rsp_tlast  = queue_ff[rptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> state_ff == SCAN_IDLE && line_pos_ff == 12'd0)
      else $error("end of input did not clear scanner");

   a_open_run_len: assert property (@(posedge clock) disable iff (reset)
      state_ff != SCAN_IDLE |-> run_len_ff != '0)
      else $error("open run with zero length");

   a_minus_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == SCAN_MINUS |-> run_len_ff == LW'(1) && run_first_ff == CH_MINUS)
      else $error("pending minus state inconsistent");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sts_pkg::*;

   class token_board;
      token_type      expected_q[$];
      int             errors;
      scan_state_type st;
      logic [11:0]    run_len;
      logic [11:0]    run_start;
      logic [11:0]    line_pos;
      logic [2:0]     kw_alive;
      logic [7:0]     run_first;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         st        = SCAN_IDLE;
         run_len   = '0;
         run_start = '0;
         line_pos  = '0;
         kw_alive  = 3'b111;
         run_first = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit is_sep(logic [7:0] b);
         case (b)
            CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL: return 1'b1;
            default:                                return 1'b0;
         endcase
      endfunction

      function bit is_num(logic [7:0] b);
         return b[7:4] == 4'h3 && b[3:0] <= 4'd9;
      endfunction

      // / + * = < >
      function bit is_arith(logic [7:0] b);
         case (b)
            8'h2F, 8'h2B, 8'h2A, 8'h3D, 8'h3C, 8'h3E: return 1'b1;
            default:                                  return 1'b0;
         endcase
      endfunction

      function string kw_word(int k);
         case (k)
            0:       return "defun";
            1:       return "if";
            default: return "setq";
         endcase
      endfunction

      // keep only keywords whose letter at position pos is b
      function logic [2:0] narrow(logic [2:0] alive, logic [11:0] pos, logic [7:0] b);
         logic [2:0] r;
         string      w;
         r = '0;
         for (int k = 0; k < 3; k++) begin
            w = kw_word(k);
            if (alive[k] && pos < w.len())
               if (w[int'(pos)] == b)
                  r[k] = 1'b1;
         end
         return r;
      endfunction

      function logic [11:0] bump(logic [11:0] v);
         return (v == LEN_LIMIT) ? v : v + 12'd1;
      endfunction

      function void push(logic [3:0] kind, logic [11:0] len, logic [7:0] first,
                         logic [11:0] start);
         token_type t;
         t.kind  = kind;
         t.len   = len;
         t.first = first;
         t.start = start;
         t.last  = 1'b0;
         expected_q.push_back(t);
      endfunction

      function void close_run();
         logic [3:0] kind;
         string      w;
         if (st == SCAN_IDLE)
            return;
         kind = KIND_NUM;
         if (st == SCAN_SYM) begin
            kind = KIND_SYM;
            for (int k = 2; k >= 0; k--) begin
               w = kw_word(k);
               if (kw_alive[k] && run_len == w.len())
                  kind = KIND_DEFUN + 4'(k);
            end
         end
         push(kind, run_len, run_first, run_start);
         st = SCAN_IDLE;
      endfunction

      function void open_run(scan_state_type s, logic [7:0] b);
         st        = s;
         run_len   = 12'd1;
         run_start = line_pos;
         run_first = b;
         kw_alive  = (s == SCAN_SYM) ? narrow(3'b111, 12'd0, b) : 3'b111;
      endfunction

      function void note_byte(logic mode, logic [7:0] b);
         int size0;
         bit fresh;
         size0 = expected_q.size();
         fresh = 1'b1;
         if (mode) begin
            close_run();
            push(KIND_END, 12'd0, 8'd0, line_pos);
            clear();
         end else begin
            case (st)
               SCAN_MINUS: begin
                  if (b == CH_SPACE) begin
                     push(KIND_OP, 12'd1, run_first, run_start);
                     st    = SCAN_IDLE;
                     fresh = 1'b0;
                  end else if (is_num(b)) begin
                     st      = SCAN_NUM;
                     run_len = bump(run_len);
                     fresh   = 1'b0;
                  end else begin
                     close_run();
                  end
               end
               SCAN_NUM: begin
                  if (is_num(b)) begin
                     run_len = bump(run_len);
                     fresh   = 1'b0;
                  end else begin
                     close_run();
                  end
               end
               SCAN_SYM: begin
                  if (!is_sep(b) && b != CH_OPEN && b != CH_CLOSE) begin
                     kw_alive = narrow(kw_alive, run_len, b);
                     run_len  = bump(run_len);
                     fresh    = 1'b0;
                  end else begin
                     close_run();
                  end
               end
               default: ;
            endcase
            if (fresh && !is_sep(b)) begin
               if (b == CH_OPEN)
                  push(KIND_OPEN, 12'd1, b, line_pos);
               else if (b == CH_CLOSE)
                  push(KIND_CLOSE, 12'd1, b, line_pos);
               else if (is_arith(b))
                  push(KIND_OP, 12'd1, b, line_pos);
               else if (b == CH_MINUS)
                  open_run(SCAN_MINUS, b);
               else if (is_num(b))
                  open_run(SCAN_NUM, b);
               else
                  open_run(SCAN_SYM, b);
            end
            line_pos = (b == CH_LF) ? 12'd0 : (line_pos == POS_LIMIT ? line_pos
                                                                      : line_pos + 12'd1);
         end
         if (expected_q.size() > size0)
            expected_q[expected_q.size() - 1].last = 1'b1;
      endfunction

      function void field_check(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t token %s mismatch: expected %0d, got %0d",
                     $time, name, exp_v, act_v);
         end
      endfunction

      function void check_token(logic [39:0] data, logic last);
         token_type t;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected token beat: expected none, got tdata=%h tlast=%b",
                     $time, data, last);
            return;
         end
         t = expected_q.pop_front();
         field_check("kind", t.kind, data[3:0]);
         field_check("length", t.len, data[15:4]);
         field_check("first_char", t.first, data[23:16]);
         field_check("start_pos", t.start, data[35:24]);
         field_check("pad", 0, data[39:36]);
         field_check("last", t.last, last);
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] text_byte
   logic        req_tuser = 1'b0;  // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [3:0] kind, [15:4] length, [23:16] first, [35:24] start
   logic        rsp_tlast;

   token_board board;
   int         send_idle;
   int         recv_idle;
   int         sent;
   int         cycles = 0;

   sexpr_token_scanner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_token(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_item(input logic mode, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_byte(mode, b);
      sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(1'b0, s[i]);
   endtask

   // hold the input until the scanner has delivered everything owed
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0)
         @(posedge clock);
   endtask

   task automatic random_phrase();
      logic [7:0] b;
      int         n;
      case ($urandom_range(19))
         0, 1:    send_item(1'b0, CH_OPEN);
         2, 3:    send_item(1'b0, CH_CLOSE);
         4, 5, 6: begin
            case ($urandom_range(2))
               0:       send_text("defun");
               1:       send_text("if");
               default: send_text("setq");
            endcase
         end
         7: begin
            // almost keywords
            case ($urandom_range(7))
               0:       send_text("defu");
               1:       send_text("defunx");
               2:       send_text("i");
               3:       send_text("iff");
               4:       send_text("set");
               5:       send_text("setqq");
               6:       send_text("sEtq");
               default: send_text("xif");
            endcase
         end
         8, 9: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               b = ($urandom_range(3) == 0) ? 8'($urandom_range(8'h21, 8'hFF))
                                            : 8'(8'h61 + $urandom_range(25));
               if (i == 0 && (b == CH_OPEN || b == CH_CLOSE || b == CH_MINUS))
                  b = 8'h7A;
               send_item(1'b0, b);
            end
         end
         10, 11: begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
               send_item(1'b0, 8'(8'h30 + $urandom_range(9)));
         end
         12: begin
            send_item(1'b0, CH_MINUS);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
               send_item(1'b0, 8'(8'h30 + $urandom_range(9)));
         end
         13: send_text("- ");
         14: begin
            case ($urandom_range(5))
               0:       send_item(1'b0, 8'h2F);
               1:       send_item(1'b0, 8'h2B);
               2:       send_item(1'b0, 8'h2A);
               3:       send_item(1'b0, 8'h3D);
               4:       send_item(1'b0, 8'h3C);
               default: send_item(1'b0, 8'h3E);
            endcase
         end
         15, 16, 17: send_item(1'b0, 8'($urandom_range(255)));
         18:         send_item(1'b1, 8'($urandom_range(255)));
         default:    send_item(1'b0, CH_MINUS);
      endcase
      if ($urandom_range(9) < 7) begin
         case ($urandom_range(9))
            0:       send_item(1'b0, CH_TAB);
            1:       send_item(1'b0, CH_CR);
            2:       send_item(1'b0, CH_LF);
            3:       send_item(1'b0, CH_NUL);
            default: send_item(1'b0, CH_SPACE);
         endcase
      end
   endtask

   initial begin
      int target;
      board     = new();
      send_idle = 8;
      recv_idle = 53;
      sent      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // parens, lone minus, minus before digit, minus before letter, all operators
      send_text("(if - -7-x)");
      send_text("/+*=<>");
      send_item(1'b0, CH_TAB);
      send_item(1'b0, CH_NUL);
      send_item(1'b0, CH_CR);
      send_item(1'b0, CH_LF);
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'hAB);
      // minus left pending at end of input
      send_item(1'b0, CH_MINUS);
      send_item(1'b1, 8'h00);

      target = sent + 270;
      while (sent < target)
         random_phrase();
      drain();

      send_idle = 53;
      recv_idle = 8;
      target = sent + 270;
      while (sent < target) begin
         random_phrase();
         if (sent > target - 135 && sent <= target - 130)
            drain();
      end
      drain();

      send_idle = 0;
      recv_idle = 0;
      target = sent + 270;
      while (sent < target)
         random_phrase();

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
